### hw/rtl/cbs_pkg.sv
// ----------------------------------------------------------------------------
// cbs_pkg: shared types, constants and arithmetic helpers
// Fixed-point formats and small functions used by the Bezier split pipeline.
// ----------------------------------------------------------------------------
package cbs_pkg;

  // Q16.16 coordinate and the wider intermediate forms
  typedef logic signed [31:0] coord_t;
  typedef logic signed [32:0] diff_t;
  typedef logic signed [50:0] prod_t;
  typedef logic signed [35:0] flat_t;
  typedef logic        [16:0] tpos_t;

  localparam int unsigned NUM_PTS    = 8;
  localparam int unsigned COORD_W    = 32;
  localparam int unsigned TPOS_W     = 17;
  localparam int unsigned IN_DATA_W  = 280;
  localparam int unsigned OUT_DATA_W = 256;
  localparam int unsigned USER_W     = 2;
  localparam int unsigned NUM_STAGES = 14;

  localparam tpos_t       T_ONE      = 17'd65536;
  localparam logic [63:0] FLAT_RESET = 64'd68719;

  // point order inside a point set
  localparam int unsigned PT_S  = 0;
  localparam int unsigned PT_C1 = 2;
  localparam int unsigned PT_C2 = 4;
  localparam int unsigned PT_E  = 6;

  // tuser bit positions
  localparam int unsigned U_STRAIGHT = 0;
  localparam int unsigned U_VISIBLE  = 1;

  // configuration register indexes
  localparam logic [0:0] REG_FLAT_THRESHOLD  = 1'b0;
  localparam logic [0:0] REG_POINT_TOLERANCE = 1'b1;

  function automatic diff_t sub33(coord_t b, coord_t a);
    return diff_t'(b) - diff_t'(a);
  endfunction

  function automatic prod_t lerp_mul(diff_t d, tpos_t t);
    logic signed [17:0] ts;
    ts = $signed({1'b0, t});
    return prod_t'(d) * prod_t'(ts);
  endfunction

  // a + floor(p / 2^16); the result always fits 32 bits
  function automatic coord_t lerp_add(coord_t a, prod_t p);
    return a + coord_t'(p[47:16]);
  endfunction

  // 3*c - 2*s - e
  function automatic flat_t flat_term(coord_t s, coord_t c, coord_t e);
    flat_t sw;
    flat_t cw;
    flat_t ew;
    sw = flat_t'(s);
    cw = flat_t'(c);
    ew = flat_t'(e);
    return (cw <<< 1) + cw - (sw <<< 1) - ew;
  endfunction

  function automatic logic [35:0] flat_abs(flat_t u);
    return u[35] ? 36'(-u) : 36'(u);
  endfunction

  function automatic logic [32:0] diff_abs(diff_t d);
    return d[32] ? 33'(-d) : 33'(d);
  endfunction

endpackage

### hw/rtl/cubic_bezier_split_top.sv
// ----------------------------------------------------------------------------
// cubic_bezier_split_top: de Casteljau split of a cubic Bezier edge
// Splits one edge at t, emits both halves with straightness and visibility.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  tdata: 8 coordinates + split_pos, tuser: flags
//  m_*      out  m_tvalid/m_tready  tdata: 8 coordinates, tuser: flags, tlast
//  cfg_*    in   cfg_valid/ready    cfg_index, cfg_data (64 bit)
//
// 14 pipeline stages plus an output register: the first half of an edge is
// shown first, and the second half follows from hold2. Two halves share the
// one output register, so while the second half waits in hold2 no new edge
// is taken unless the last stage is empty. A stall freezes the whole pipeline
// unless its last stage is empty. Reset clears valid bits, sets config defaults.
// ----------------------------------------------------------------------------
module cubic_bezier_split_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // sx, sy, c1x, c1y, c2x, c2y, ex, ey (32 each), split_pos (17), zero pad
  input  logic [cbs_pkg::IN_DATA_W-1:0]  s_tdata,
  // is_straight, is_visible
  input  logic [cbs_pkg::USER_W-1:0]     s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // out_start_x/y, out_ctrl1_x/y, out_ctrl2_x/y, out_end_x/y (32 each)
  output logic [cbs_pkg::OUT_DATA_W-1:0] m_tdata,
  // out_straight, out_visible
  output logic [cbs_pkg::USER_W-1:0]     m_tuser,
  output logic                           m_tlast,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [0:0]                     cfg_index,
  input  logic [63:0]                    cfg_data
);

  localparam int unsigned LAST = cbs_pkg::NUM_STAGES - 1;

  logic [63:0] flat_threshold;
  logic [15:0] point_tolerance;

  logic [cbs_pkg::NUM_STAGES-1:0] vld;
  logic adv;
  logic out_free;
  logic hold2;
  logic [cbs_pkg::OUT_DATA_W-1:0] hold2_data;
  logic [cbs_pkg::USER_W-1:0]     hold2_user;

  cbs_pkg::tpos_t t_in;

  // stage registers
  cbs_pkg::coord_t s1_pt [8];
  cbs_pkg::tpos_t  s1_t;
  logic            s1_st, s1_vis;

  cbs_pkg::coord_t s2_pt [8];
  cbs_pkg::diff_t  s2_d [2][3];
  cbs_pkg::tpos_t  s2_t;
  logic            s2_st, s2_vis;

  cbs_pkg::coord_t s3_pt [8];
  cbs_pkg::prod_t  s3_p [2][3];
  cbs_pkg::tpos_t  s3_t;
  logic            s3_st, s3_vis;

  cbs_pkg::coord_t s4_s [2], s4_e [2], s4_a [2], s4_c [2], s4_d [2];
  cbs_pkg::tpos_t  s4_t;
  logic            s4_st, s4_vis;

  cbs_pkg::coord_t s5_s [2], s5_e [2], s5_a [2], s5_d [2];
  cbs_pkg::diff_t  s5_df [2][2];
  cbs_pkg::tpos_t  s5_t;
  logic            s5_st, s5_vis;

  cbs_pkg::coord_t s6_s [2], s6_e [2], s6_a [2], s6_d [2];
  cbs_pkg::prod_t  s6_p [2][2];
  cbs_pkg::coord_t s6_lo [2], s6_hi [2];
  cbs_pkg::tpos_t  s6_t;
  logic            s6_st, s6_vis;

  cbs_pkg::coord_t s7_s [2], s7_e [2], s7_a [2], s7_d [2], s7_r1 [2], s7_r2 [2];
  cbs_pkg::tpos_t  s7_t;
  logic            s7_vis;

  cbs_pkg::coord_t s8_s [2], s8_e [2], s8_a [2], s8_d [2], s8_r1 [2], s8_r2 [2];
  cbs_pkg::diff_t  s8_df [2];
  cbs_pkg::tpos_t  s8_t;
  logic            s8_vis;

  cbs_pkg::coord_t s9_s [2], s9_e [2], s9_a [2], s9_d [2], s9_r1 [2], s9_r2 [2];
  cbs_pkg::prod_t  s9_p [2];
  logic            s9_vis;

  cbs_pkg::coord_t s10_h [2][8];
  logic            s10_vis;

  cbs_pkg::coord_t s11_h [2][8];
  cbs_pkg::flat_t  s11_u [2][2][2];
  cbs_pkg::diff_t  s11_se [2][2];
  logic            s11_vis;
  logic [35:0]     u_abs [2][2][2];

  cbs_pkg::coord_t s12_h [2][8];
  logic [31:0]     s12_mag [2][2][2];
  logic            s12_sat [2][2][2];
  logic            s12_eq [2];
  logic            s12_vis;

  cbs_pkg::coord_t s13_h [2][8];
  logic [63:0]     s13_sq [2][2][2];
  logic            s13_eq [2];
  logic            s13_vis;

  cbs_pkg::coord_t s14_h [2][8];
  logic [63:0]     s14_sum [2];
  logic            s14_eq [2];
  logic            s14_vis;

  logic [cbs_pkg::OUT_DATA_W-1:0] half_data [2];
  logic                           half_flat [2];

  function automatic logic [63:0] max64(logic [63:0] a, logic [63:0] b);
    return (a < b) ? b : a;
  endfunction

  function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      flat_threshold  <= cbs_pkg::FLAT_RESET;
      point_tolerance <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        cbs_pkg::REG_FLAT_THRESHOLD:  flat_threshold  <= cfg_data;
        cbs_pkg::REG_POINT_TOLERANCE: point_tolerance <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // flow control: the whole pipe moves together, and stalls only while its tail holds an edge the output cannot take
  assign out_free = !m_tvalid || m_tready;
  assign adv      = !vld[LAST] || (out_free && !hold2);
  assign s_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAST-1:0], s_tvalid};
    end
  end

  always_comb begin
    t_in = s_tdata[256 +: cbs_pkg::TPOS_W];
    if (t_in > cbs_pkg::T_ONE) begin
      t_in = cbs_pkg::T_ONE;
    end
  end

  always_comb begin
    for (int h = 0; h < 2; h++) begin
      for (int ax = 0; ax < 2; ax++) begin
        for (int w = 0; w < 2; w++) begin
          u_abs[h][ax][w] = cbs_pkg::flat_abs(s11_u[h][ax][w]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // stage 1: capture
      for (int k = 0; k < 8; k++) begin
        s1_pt[k] <= s_tdata[cbs_pkg::COORD_W*k +: cbs_pkg::COORD_W];
      end
      s1_t   <= t_in;
      s1_st  <= s_tuser[cbs_pkg::U_STRAIGHT];
      s1_vis <= s_tuser[cbs_pkg::U_VISIBLE];

      // stage 2: first-level differences
      for (int ax = 0; ax < 2; ax++) begin
        s2_d[ax][0] <= cbs_pkg::sub33(s1_pt[cbs_pkg::PT_C1+ax], s1_pt[cbs_pkg::PT_S+ax]);
        s2_d[ax][1] <= cbs_pkg::sub33(s1_pt[cbs_pkg::PT_C2+ax], s1_pt[cbs_pkg::PT_C1+ax]);
        s2_d[ax][2] <= cbs_pkg::sub33(s1_pt[cbs_pkg::PT_E+ax], s1_pt[cbs_pkg::PT_C2+ax]);
      end
      s2_pt  <= s1_pt;
      s2_t   <= s1_t;
      s2_st  <= s1_st;
      s2_vis <= s1_vis;

      // stage 3: first-level products
      for (int ax = 0; ax < 2; ax++) begin
        for (int j = 0; j < 3; j++) begin
          s3_p[ax][j] <= cbs_pkg::lerp_mul(s2_d[ax][j], s2_t);
        end
      end
      s3_pt  <= s2_pt;
      s3_t   <= s2_t;
      s3_st  <= s2_st;
      s3_vis <= s2_vis;

      // stage 4: a, c, d
      for (int ax = 0; ax < 2; ax++) begin
        s4_a[ax] <= cbs_pkg::lerp_add(s3_pt[cbs_pkg::PT_S+ax], s3_p[ax][0]);
        s4_c[ax] <= cbs_pkg::lerp_add(s3_pt[cbs_pkg::PT_C1+ax], s3_p[ax][1]);
        s4_d[ax] <= cbs_pkg::lerp_add(s3_pt[cbs_pkg::PT_C2+ax], s3_p[ax][2]);
        s4_s[ax] <= s3_pt[cbs_pkg::PT_S+ax];
        s4_e[ax] <= s3_pt[cbs_pkg::PT_E+ax];
      end
      s4_t   <= s3_t;
      s4_st  <= s3_st;
      s4_vis <= s3_vis;

      // stage 5: second-level differences
      for (int ax = 0; ax < 2; ax++) begin
        s5_df[ax][0] <= cbs_pkg::sub33(s4_c[ax], s4_a[ax]);
        s5_df[ax][1] <= cbs_pkg::sub33(s4_d[ax], s4_c[ax]);
      end
      s5_s   <= s4_s;
      s5_e   <= s4_e;
      s5_a   <= s4_a;
      s5_d   <= s4_d;
      s5_t   <= s4_t;
      s5_st  <= s4_st;
      s5_vis <= s4_vis;

      // stage 6: second-level products, keep the bases a and c
      for (int ax = 0; ax < 2; ax++) begin
        s6_p[ax][0] <= cbs_pkg::lerp_mul(s5_df[ax][0], s5_t);
        s6_p[ax][1] <= cbs_pkg::lerp_mul(s5_df[ax][1], s5_t);
        s6_lo[ax]   <= s5_a[ax];
        s6_hi[ax]   <= cbs_pkg::coord_t'(s5_df[ax][0] + cbs_pkg::diff_t'(s5_a[ax]));
      end
      s6_s   <= s5_s;
      s6_e   <= s5_e;
      s6_a   <= s5_a;
      s6_d   <= s5_d;
      s6_t   <= s5_t;
      s6_st  <= s5_st;
      s6_vis <= s5_vis;

      // stage 7: r1, r2; a straight edge takes start and end instead
      for (int ax = 0; ax < 2; ax++) begin
        s7_r1[ax] <= s6_st ? s6_s[ax] : cbs_pkg::lerp_add(s6_lo[ax], s6_p[ax][0]);
        s7_r2[ax] <= s6_st ? s6_e[ax] : cbs_pkg::lerp_add(s6_hi[ax], s6_p[ax][1]);
      end
      s7_s   <= s6_s;
      s7_e   <= s6_e;
      s7_a   <= s6_a;
      s7_d   <= s6_d;
      s7_t   <= s6_t;
      s7_vis <= s6_vis;

      // stage 8: third-level difference
      for (int ax = 0; ax < 2; ax++) begin
        s8_df[ax] <= cbs_pkg::sub33(s7_r2[ax], s7_r1[ax]);
      end
      s8_s   <= s7_s;
      s8_e   <= s7_e;
      s8_a   <= s7_a;
      s8_d   <= s7_d;
      s8_r1  <= s7_r1;
      s8_r2  <= s7_r2;
      s8_t   <= s7_t;
      s8_vis <= s7_vis;

      // stage 9: third-level product
      for (int ax = 0; ax < 2; ax++) begin
        s9_p[ax] <= cbs_pkg::lerp_mul(s8_df[ax], s8_t);
      end
      s9_s   <= s8_s;
      s9_e   <= s8_e;
      s9_a   <= s8_a;
      s9_d   <= s8_d;
      s9_r1  <= s8_r1;
      s9_r2  <= s8_r2;
      s9_vis <= s8_vis;

      // stage 10: split point m, form both halves
      for (int ax = 0; ax < 2; ax++) begin
        s10_h[0][cbs_pkg::PT_S+ax]  <= s9_s[ax];
        s10_h[0][cbs_pkg::PT_C1+ax] <= s9_a[ax];
        s10_h[0][cbs_pkg::PT_C2+ax] <= s9_r1[ax];
        s10_h[0][cbs_pkg::PT_E+ax]  <= cbs_pkg::lerp_add(s9_r1[ax], s9_p[ax]);
        s10_h[1][cbs_pkg::PT_S+ax]  <= cbs_pkg::lerp_add(s9_r1[ax], s9_p[ax]);
        s10_h[1][cbs_pkg::PT_C1+ax] <= s9_r2[ax];
        s10_h[1][cbs_pkg::PT_C2+ax] <= s9_d[ax];
        s10_h[1][cbs_pkg::PT_E+ax]  <= s9_e[ax];
      end
      s10_vis <= s9_vis;

      // stage 11: flatness terms and start-end differences
      for (int h = 0; h < 2; h++) begin
        for (int ax = 0; ax < 2; ax++) begin
          s11_u[h][ax][0] <= cbs_pkg::flat_term(s10_h[h][cbs_pkg::PT_S+ax],
                                                s10_h[h][cbs_pkg::PT_C1+ax],
                                                s10_h[h][cbs_pkg::PT_E+ax]);
          s11_u[h][ax][1] <= cbs_pkg::flat_term(s10_h[h][cbs_pkg::PT_E+ax],
                                                s10_h[h][cbs_pkg::PT_C2+ax],
                                                s10_h[h][cbs_pkg::PT_S+ax]);
          s11_se[h][ax]   <= cbs_pkg::sub33(s10_h[h][cbs_pkg::PT_S+ax],
                                            s10_h[h][cbs_pkg::PT_E+ax]);
        end
      end
      s11_h   <= s10_h;
      s11_vis <= s10_vis;

      // stage 12: magnitudes, overflow marks, tolerance check
      for (int h = 0; h < 2; h++) begin
        for (int ax = 0; ax < 2; ax++) begin
          for (int w = 0; w < 2; w++) begin
            s12_mag[h][ax][w] <= u_abs[h][ax][w][31:0];
            s12_sat[h][ax][w] <= |u_abs[h][ax][w][35:32];
          end
        end
        s12_eq[h] <= (cbs_pkg::diff_abs(s11_se[h][0]) <= {17'd0, point_tolerance}) &&
                     (cbs_pkg::diff_abs(s11_se[h][1]) <= {17'd0, point_tolerance});
      end
      s12_h   <= s11_h;
      s12_vis <= s11_vis;

      // stage 13: saturating squares
      for (int h = 0; h < 2; h++) begin
        for (int ax = 0; ax < 2; ax++) begin
          for (int w = 0; w < 2; w++) begin
            s13_sq[h][ax][w] <= s12_sat[h][ax][w] ? '1 :
                                64'(s12_mag[h][ax][w]) * 64'(s12_mag[h][ax][w]);
          end
        end
      end
      s13_eq  <= s12_eq;
      s13_h   <= s12_h;
      s13_vis <= s12_vis;

      // stage 14: per-axis maximum, saturating sum
      for (int h = 0; h < 2; h++) begin
        s14_sum[h] <= sat_sum(max64(s13_sq[h][0][0], s13_sq[h][0][1]),
                              max64(s13_sq[h][1][0], s13_sq[h][1][1]));
      end
      s14_eq  <= s13_eq;
      s14_h   <= s13_h;
      s14_vis <= s13_vis;
    end
  end

  always_comb begin
    for (int h = 0; h < 2; h++) begin
      for (int k = 0; k < 8; k++) begin
        half_data[h][cbs_pkg::COORD_W*k +: cbs_pkg::COORD_W] = s14_h[h][k];
      end
      half_flat[h] = s14_eq[h] || (s14_sum[h] < flat_threshold);
    end
  end

  // output register; the second half waits in hold2 while the first is shown
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      hold2    <= 1'b0;
    end else if (out_free) begin
      if (hold2) begin
        m_tvalid <= 1'b1;
        hold2    <= 1'b0;
      end else if (vld[LAST]) begin
        m_tvalid <= 1'b1;
        hold2    <= 1'b1;
      end else begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (hold2) begin
        m_tdata <= hold2_data;
        m_tuser <= hold2_user;
        m_tlast <= 1'b1;
      end else if (vld[LAST]) begin
        m_tdata    <= half_data[0];
        m_tuser    <= {s14_vis, half_flat[0]};
        m_tlast    <= 1'b0;
        hold2_data <= half_data[1];
        hold2_user <= {s14_vis, half_flat[1]};
      end
    end
  end

endmodule

### sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the cubic Bezier split block
// Streams corner-case and random edges through the block under several
// threshold and tolerance settings, with random gaps and output stalls, and
// checks every emitted half against a de Casteljau predictor kept here.
// ----------------------------------------------------------------------------

typedef longint pts_t [8];

typedef struct {
  cbs_pkg::coord_t pt [8];
  cbs_pkg::tpos_t  tpos;
  bit              straight;
  bit              visible;
} bez_edge_t;

typedef struct {
  logic            last;
  cbs_pkg::coord_t pt [8];
  logic            straight;
  logic            visible;
} bez_half_t;

class split_scoreboard;
  bit [63:0]   flat_limit;
  bit [15:0]   tol;
  bez_half_t   halves_due [$];
  int unsigned mismatches;
  int unsigned halves_seen;
  int unsigned edges_seen;

  function new();
    flat_limit  = cbs_pkg::FLAT_RESET;
    tol         = 16'd0;
    mismatches  = 0;
    halves_seen = 0;
    edges_seen  = 0;
  endfunction

  function void write_reg(logic [0:0] idx, logic [63:0] data);
    if (idx == cbs_pkg::REG_FLAT_THRESHOLD) begin
      flat_limit = data;
    end else if (idx == cbs_pkg::REG_POINT_TOLERANCE) begin
      tol = data[15:0];
    end
  endfunction

  function int unsigned pending();
    return halves_due.size();
  endfunction

  // a + floor(t * (b - a) / 2^16)
  function longint lerp_q16(longint a, longint b, longint t);
    return a + (((b - a) * t) >>> 16);
  endfunction

  function bit [63:0] mag(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  function bit [63:0] sq_sat(longint v);
    bit [63:0] m;
    m = mag(v);
    if (m >= 64'h1_0000_0000) return '1;
    return m * m;
  endfunction

  function bit [63:0] axis_measure(longint s, longint c1, longint c2, longint e);
    bit [63:0] a;
    bit [63:0] b;
    a = sq_sat(3 * c1 - 2 * s - e);
    b = sq_sat(3 * c2 - 2 * e - s);
    return (a < b) ? b : a;
  endfunction

  function bit half_straight(pts_t p);
    bit [63:0] mx;
    bit [63:0] my;
    bit [63:0] sum;
    if (mag(p[0] - p[6]) <= tol && mag(p[1] - p[7]) <= tol) return 1'b1;
    mx  = axis_measure(p[0], p[2], p[4], p[6]);
    my  = axis_measure(p[1], p[3], p[5], p[7]);
    sum = mx + my;
    if (sum < mx) sum = '1;
    return sum < flat_limit;
  endfunction

  function bez_half_t make_half(bit last, pts_t p, bit vis);
    bez_half_t h;
    h.last = last;
    for (int k = 0; k < 8; k++) h.pt[k] = cbs_pkg::coord_t'(p[k]);
    h.straight = half_straight(p);
    h.visible  = vis;
    return h;
  endfunction

  // split one accepted edge and queue both halves
  function void note_edge(bez_edge_t e);
    pts_t   h1;
    pts_t   h2;
    longint t, s, c1, c2, en, a, d, c, r1, r2, m;
    t = (e.tpos > cbs_pkg::T_ONE) ? longint'(cbs_pkg::T_ONE) : longint'(e.tpos);
    for (int k = 0; k < 2; k++) begin
      s  = longint'(e.pt[k]);
      c1 = longint'(e.pt[2 + k]);
      c2 = longint'(e.pt[4 + k]);
      en = longint'(e.pt[6 + k]);
      a  = lerp_q16(s, c1, t);
      d  = lerp_q16(c2, en, t);
      if (e.straight) begin
        r1 = s;
        r2 = en;
      end else begin
        c  = lerp_q16(c1, c2, t);
        r1 = lerp_q16(a, c, t);
        r2 = lerp_q16(c, d, t);
      end
      m = lerp_q16(r1, r2, t);
      h1[k] = s;  h1[2 + k] = a;  h1[4 + k] = r1; h1[6 + k] = m;
      h2[k] = m;  h2[2 + k] = r2; h2[4 + k] = d;  h2[6 + k] = en;
    end
    halves_due.push_back(make_half(1'b0, h1, e.visible));
    halves_due.push_back(make_half(1'b1, h2, e.visible));
    edges_seen++;
  endfunction

  function void flag(string what, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("%s mismatch at half %0d: expected %h, got %h", what, halves_seen, want, got);
  endfunction

  function void check_half(bez_half_t got);
    bez_half_t want;
    if (halves_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("half received with no edge outstanding");
      return;
    end
    want = halves_due.pop_front();
    if (got.last !== want.last) flag("tlast", want.last, got.last);
    for (int k = 0; k < 8; k++)
      if (got.pt[k] !== want.pt[k]) flag($sformatf("point word %0d", k), want.pt[k], got.pt[k]);
    if (got.straight !== want.straight) flag("straight", want.straight, got.straight);
    if (got.visible !== want.visible) flag("visible", want.visible, got.visible);
    halves_seen++;
  endfunction
endclass

module tb_top;
  import cbs_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [USER_W-1:0]     s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [USER_W-1:0]     m_tuser;
  logic                  m_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [0:0]            cfg_index = '0;
  logic [63:0]           cfg_data = '0;

  bit              calm = 1'b0;
  int unsigned     settings = 1;
  split_scoreboard sb;
  bez_half_t       mon_half;
  bez_edge_t       mon_edge;

  cubic_bezier_split_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  always @(negedge clk) m_tready <= calm || ($urandom_range(0, 99) >= 24);

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        mon_half.last = m_tlast;
        for (int k = 0; k < NUM_PTS; k++) mon_half.pt[k] = m_tdata[COORD_W*k +: COORD_W];
        mon_half.straight = m_tuser[U_STRAIGHT];
        mon_half.visible  = m_tuser[U_VISIBLE];
        sb.check_half(mon_half);
      end
      if (s_tvalid && s_tready) begin
        for (int k = 0; k < NUM_PTS; k++) mon_edge.pt[k] = s_tdata[COORD_W*k +: COORD_W];
        mon_edge.tpos     = s_tdata[NUM_PTS*COORD_W +: TPOS_W];
        mon_edge.straight = s_tuser[U_STRAIGHT];
        mon_edge.visible  = s_tuser[U_VISIBLE];
        sb.note_edge(mon_edge);
      end
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
    end
  end

  function automatic coord_t pick_extreme();
    case ($urandom_range(0, 4))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return 32'sd0;
      3: return -32'sd1;
      default: return 32'sd1;
    endcase
  endfunction

  function automatic bez_edge_t make_edge();
    bez_edge_t   e;
    int unsigned kind;
    int unsigned pick;
    int          bx, by, dx, dy, jit;
    kind = $urandom_range(0, 99);
    if (kind < 25) begin
      for (int k = 0; k < 8; k++) e.pt[k] = $urandom;
    end else if (kind < 45) begin
      for (int k = 0; k < 8; k++) e.pt[k] = int'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
    end else if (kind < 70) begin
      // nearly collinear points, so the flatness measure lands near the limit
      bx  = int'($urandom_range(0, 32'h4000_0000)) - 32'h2000_0000;
      by  = int'($urandom_range(0, 32'h4000_0000)) - 32'h2000_0000;
      dx  = int'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
      dy  = int'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
      jit = 1 << $urandom_range(0, 14);
      for (int k = 0; k < 4; k++) begin
        e.pt[2*k]     = bx + k * dx + int'($urandom_range(0, jit)) - jit / 2;
        e.pt[2*k + 1] = by + k * dy + int'($urandom_range(0, jit)) - jit / 2;
      end
    end else if (kind < 85) begin
      // end point close to the start point
      for (int k = 0; k < 6; k++) e.pt[k] = $urandom;
      e.pt[6] = e.pt[0] + int'($urandom_range(0, 140000)) - 70000;
      e.pt[7] = e.pt[1] + int'($urandom_range(0, 140000)) - 70000;
    end else begin
      for (int k = 0; k < 8; k++) e.pt[k] = pick_extreme();
    end
    pick = $urandom_range(0, 99);
    if (pick < 5) e.tpos = '0;
    else if (pick < 10) e.tpos = T_ONE;
    else if (pick < 15) e.tpos = 17'($urandom_range(65537, 131071));
    else e.tpos = 17'($urandom_range(0, 65536));
    e.straight = ($urandom_range(0, 99) < 30);
    e.visible  = 1'($urandom_range(0, 1));
    return e;
  endfunction

  // caller stands at a falling edge; returns at the falling edge after the item
  task automatic send_edge(input bez_edge_t e);
    logic [IN_DATA_W-1:0] word;
    logic [USER_W-1:0]    flags;
    word = '0;
    for (int k = 0; k < NUM_PTS; k++) word[COORD_W*k +: COORD_W] = e.pt[k];
    word[NUM_PTS*COORD_W +: TPOS_W] = e.tpos;
    flags = '0;
    flags[U_STRAIGHT] = e.straight;
    flags[U_VISIBLE]  = e.visible;
    while (!calm && $urandom_range(0, 99) < 24) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tdata  <= word;
    s_tuser  <= flags;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // hold the input until every queued half has come out
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic set_regs(input logic [63:0] thr, input logic [15:0] tolv);
    cfg_index <= REG_FLAT_THRESHOLD;
    cfg_data  <= thr;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_index <= REG_POINT_TOLERANCE;
    cfg_data  <= {48'd0, tolv};
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
    settings++;
  endtask

  task automatic directed_part();
    bez_edge_t e;
    tpos_t     sweep [8];
    sweep = '{17'd0, 17'd1, 17'd32767, 17'd32768, 17'd65535, 17'd65536, 17'd65537, 17'd131071};
    for (int i = 0; i < 20; i++) begin
      e = make_edge();
      case (i)
        0: begin
          for (int k = 0; k < 8; k++) e.pt[k] = 32'sd0;
          e.tpos = '0; e.straight = 1'b0; e.visible = 1'b0;
        end
        1: begin
          for (int k = 0; k < 8; k++) e.pt[k] = 32'sh7fff_ffff;
          e.tpos = T_ONE; e.visible = 1'b1;
        end
        2: begin
          for (int k = 0; k < 8; k++) e.pt[k] = 32'sh8000_0000;
          e.tpos = 17'd32768;
        end
        3, 4: begin
          // swing between the coordinate extremes: saturating flatness
          for (int k = 0; k < 8; k++) e.pt[k] = ((k / 2) % 2) ? 32'sh7fff_ffff : 32'sh8000_0000;
          e.tpos = 17'd1; e.straight = (i == 4);
        end
        5: begin
          // points on a line: flat under the reset threshold
          for (int k = 0; k < 4; k++) begin
            e.pt[2*k] = k * 65536; e.pt[2*k + 1] = 32'sd0;
          end
          e.straight = 1'b0;
        end
        6: begin
          // start equals end on a bulging curve
          e.pt[6] = e.pt[0]; e.pt[7] = e.pt[1]; e.straight = 1'b0;
        end
        7: begin
          // negative products round toward minus infinity
          for (int k = 0; k < 8; k++) e.pt[k] = (k < 2) ? 32'sd0 : -32'sd1;
          e.tpos = 17'd1; e.straight = 1'b0;
        end
        8: begin
          for (int k = 0; k < 8; k++) e.pt[k] = (k % 2) ? 32'sh8000_0000 : 32'sh7fff_ffff;
          e.tpos = 17'd131071;
        end
        9, 10, 11: begin
          e.tpos = 17'(65537 + i); e.straight = i[0]; e.visible = i[1];
        end
        default: begin
          e.tpos = sweep[i - 12]; e.straight = i[0]; e.visible = i[1];
        end
      endcase
      send_edge(e);
    end
    drain();
  endtask

  task automatic random_phase(input int unsigned n, input bit quiet, input bit hold_midway);
    for (int unsigned i = 0; i < n; i++) begin
      calm = quiet && (i >= n / 4) && (i < n / 2);
      if (hold_midway && i == n / 2) drain();
      send_edge(make_edge());
    end
    calm = 1'b0;
    drain();
  endtask

  initial begin
    sb = new();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    directed_part();
    set_regs(64'd0, 16'd0);
    random_phase(200, 1'b0, 1'b0);
    set_regs('1, 16'hffff);
    random_phase(200, 1'b1, 1'b0);
    set_regs({$urandom, $urandom} >> $urandom_range(0, 63), 16'($urandom));
    random_phase(200, 1'b0, 1'b1);
    set_regs(64'd1 << $urandom_range(16, 44), 16'($urandom_range(0, 255)));
    random_phase(200, 1'b0, 1'b0);
    repeat (40) @(posedge clk);
    $display("Run covered %0d edges, %0d halves checked, %0d register settings",
             sb.edges_seen, sb.halves_seen, settings);
    $display("Mismatches: %0d, halves still outstanding: %0d", sb.mismatches, sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
